>>> sv/quoted_argument_splitter_assert.svh
// Assertion shorthands, clocked on clk and disabled during reset
`ifndef QUOTED_ARGUMENT_SPLITTER_ASSERT_SVH
`define QUOTED_ARGUMENT_SPLITTER_ASSERT_SVH

// Same-cycle check
`define QAS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Next-cycle check
`define QAS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> sv/qas_pkg.sv
package qas_pkg;

	localparam int DEF_ARG_LEN_CAP = 256;
	localparam logic [7:0] MAX_ARGS_RST = 8'd16;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_ESC = 2'd1;
	localparam logic [1:0] ST_SQ  = 2'd2;
	localparam logic [1:0] ST_DQ  = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [1:0] status;
		logic       truncated;
		logic       dropped;
		logic [7:0] arg_count;
	} res_t;

	// one input item's results: r0 always, r1 when two is set
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} ent_t;

	function automatic res_t mk_res(input logic [1:0] k, input logic [7:0] d,
		input logic [1:0] s, input logic t, input logic dr, input logic [7:0] n);
		res_t r;
		r.kind      = k;
		r.data      = d;
		r.status    = s;
		r.truncated = t;
		r.dropped   = dr;
		r.arg_count = n;
		return r;
	endfunction

endpackage

>>> sv/qas_front.sv
module qas_front #(
	parameter int ARG_LEN_CAP = qas_pkg::DEF_ARG_LEN_CAP
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    ch,
	input  logic          in_acc,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_data,
	output logic          ent_valid,
	output qas_pkg::ent_t ent
);
	import qas_pkg::*;

	localparam int LEN_W = $clog2(ARG_LEN_CAP);
	localparam logic [LEN_W-1:0] LEN_LIM = LEN_W'(ARG_LEN_CAP - 1);

	localparam logic [7:0] C_SP  = 8'h20;
	localparam logic [7:0] C_TAB = 8'h09;
	localparam logic [7:0] C_LF  = 8'h0a;
	localparam logic [7:0] C_BT  = 8'h60;
	localparam logic [7:0] C_DOL = 8'h24;
	localparam logic [7:0] C_BSL = 8'h5c;
	localparam logic [7:0] C_SQ  = 8'h27;
	localparam logic [7:0] C_DQ  = 8'h22;

	typedef enum logic [1:0] {M_DELIM, M_ARG, M_SQ, M_DQ} mode_t;

	mode_t            mode_q, n_mode;
	logic             esc_q, n_esc;
	logic [LEN_W-1:0] len_q, len;
	logic [7:0]       args_q, args;
	logic             trunc_q, trunc;
	logic             drop_q, drop;
	logic [7:0]       max_args_q;

	logic [1:0] nk;
	logic [7:0] kc [2];
	logic       fin, done;
	logic [1:0] st;
	logic [1:0] cnt;
	res_t       r [2];
	logic       is_sep, dq_esc;

	assign is_sep = (ch == C_SP) || (ch == C_TAB) || (ch == C_LF);
	assign dq_esc = (ch == C_BSL) || (ch == C_DQ) || (ch == C_BT) || (ch == C_DOL);

	always_comb begin
		n_mode = mode_q;
		n_esc  = esc_q;
		len    = len_q;
		args   = args_q;
		trunc  = trunc_q;
		drop   = drop_q;
		nk     = 2'd0;
		kc[0]  = ch;
		kc[1]  = ch;
		fin    = 1'b0;
		done   = 1'b0;
		st     = ST_OK;
		cnt    = 2'd0;
		r[0]   = '0;
		r[1]   = '0;

		// classify
		if (ch == 8'd0) begin
			done = 1'b1;
			priority if (esc_q) st = ST_ESC;
			else if (mode_q == M_SQ) st = ST_SQ;
			else if (mode_q == M_DQ) st = ST_DQ;
			else fin = (mode_q == M_ARG);
		end else if (esc_q) begin
			n_esc = 1'b0;
			// backslash-newline is a continuation
			if (ch != C_LF) begin
				if (mode_q == M_DQ) begin
					if (!dq_esc) begin
						nk    = 2'd2;
						kc[0] = C_BSL;
					end else begin
						nk = 2'd1;
					end
				end else begin
					nk     = 2'd1;
					n_mode = M_ARG;
				end
			end
		end else begin
			unique case (mode_q)
				M_DELIM, M_ARG: begin
					priority if (ch == C_SQ) n_mode = M_SQ;
					else if (ch == C_DQ) n_mode = M_DQ;
					else if (ch == C_BSL) n_esc = 1'b1;
					else if (is_sep) begin
						fin    = (mode_q == M_ARG);
						n_mode = M_DELIM;
					end else begin
						nk     = 2'd1;
						n_mode = M_ARG;
					end
				end
				M_SQ: begin
					if (ch == C_SQ) n_mode = M_ARG;
					else nk = 2'd1;
				end
				M_DQ: begin
					priority if (ch == C_DQ) n_mode = M_ARG;
					else if (ch == C_BSL) n_esc = 1'b1;
					else nk = 2'd1;
				end
			endcase
		end

		// carry out: kept bytes, then argument end, then string status
		for (int i = 0; i < 2; i++) begin
			if (2'(i) < nk) begin
				if (len < LEN_LIM) begin
					len = len + LEN_W'(1);
					if (args < max_args_q) begin
						r[cnt[0:0]] = mk_res(KIND_BYTE, kc[i], ST_OK, trunc, drop, args);
						cnt = cnt + 2'd1;
					end
				end else begin
					trunc = 1'b1;
				end
			end
		end
		if (fin) begin
			if (args < max_args_q) begin
				args = args + 8'd1;
				r[cnt[0:0]] = mk_res(KIND_END, 8'd0, ST_OK, trunc, drop, args);
				cnt = cnt + 2'd1;
			end else begin
				drop = 1'b1;
			end
			len = '0;
		end
		if (done) begin
			r[cnt[0:0]] = mk_res(KIND_DONE, 8'd0, st, trunc, drop, args);
			cnt = cnt + 2'd1;
			n_mode = M_DELIM;
			n_esc  = 1'b0;
			len    = '0;
			args   = 8'd0;
			trunc  = 1'b0;
			drop   = 1'b0;
		end
	end

	assign ent_valid = in_acc && (cnt != 2'd0);
	assign ent.two   = (cnt == 2'd2);
	assign ent.r0    = r[0];
	assign ent.r1    = r[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_DELIM;
			esc_q      <= 1'b0;
			len_q      <= '0;
			args_q     <= 8'd0;
			trunc_q    <= 1'b0;
			drop_q     <= 1'b0;
			max_args_q <= MAX_ARGS_RST;
		end else begin
			if (cfg_we) max_args_q <= cfg_data;
			if (in_acc) begin
				mode_q  <= n_mode;
				esc_q   <= n_esc;
				len_q   <= len;
				args_q  <= args;
				trunc_q <= trunc;
				drop_q  <= drop;
			end
		end
	end

endmodule

>>> sv/qas_queue.sv
module qas_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  qas_pkg::ent_t push_ent,
	input  logic          pop,
	output qas_pkg::ent_t head,
	output logic          empty,
	output logic          full
);
	import qas_pkg::*;

	localparam int CNT_W = QPTR_W + 1;

	ent_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;

	assign head  = mem_q[rd_q];
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(QDEPTH));

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_W'(1);
			if (pop) rd_q <= rd_q + QPTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

>>> sv/qas_back.sv
`include "quoted_argument_splitter_assert.svh"

module qas_back (
	input  logic          clk,
	input  logic          arst_n,
	input  qas_pkg::ent_t head,
	input  logic          empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    kind,
	output logic [7:0]    data,
	output logic [1:0]    status,
	output logic          truncated,
	output logic          dropped,
	output logic [7:0]    arg_count,
	output logic          last
);
	import qas_pkg::*;

	logic out_valid_q, last_q, hold_valid_q;
	res_t out_q, hold_q;
	logic load;

	// output register frees up when empty or taken this cycle
	assign load = !out_valid_q || !out_stall;
	assign pop  = load && !hold_valid_q && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (load) begin
			if (hold_valid_q) begin
				out_valid_q  <= 1'b1;
				hold_valid_q <= 1'b0;
			end else if (!empty) begin
				out_valid_q  <= 1'b1;
				hold_valid_q <= head.two;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (hold_valid_q) begin
				out_q  <= hold_q;
				last_q <= 1'b1;
			end else if (!empty) begin
				out_q  <= head.r0;
				last_q <= !head.two;
				hold_q <= head.r1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = out_q.kind;
	assign data      = out_q.data;
	assign status    = out_q.status;
	assign truncated = out_q.truncated;
	assign dropped   = out_q.dropped;
	assign arg_count = out_q.arg_count;
	assign last      = last_q;

	`QAS_ASSERT(a_pair_second, hold_valid_q |-> out_valid_q && !last_q, "held result without first")
	`QAS_ASSERT_NEXT(a_pair_follows, out_valid_q && !last_q && !out_stall, out_valid_q && last_q, "second result of an item did not follow")
	`QAS_ASSERT(a_done_last, out_valid_q && kind == KIND_DONE |-> last_q, "string status not last")
	`QAS_ASSERT(a_data_zero, out_valid_q && kind != KIND_BYTE |-> data == 8'd0 && (kind == KIND_DONE || status == ST_OK), "mark carries data or status")

endmodule

>>> sv/quoted_argument_splitter.sv
// Quoted argument splitter: splits a byte stream into shell-style arguments.
// Input channel (in_valid, in_stall, ch): one character per item; a zero byte
// ends the string. Output channel (out_valid, out_stall, kind ... last): one
// result per item; kind is an argument byte, an end-of-argument mark or the
// string status. Each input item gives zero, one or two results, and last
// marks the final result of an input item.
// Config channel (cfg_valid, cfg_ready, max_args): always ready; write only
// while the block is idle.
// The results of an item are written to a result queue when the item is
// accepted, and are then loaded into the output register.
// Throughput: one item per cycle while in_stall is low; the lexer registers
// its state on each accepted item and pushes into a 4-entry result queue.
// The output side delivers one result per cycle while out_stall is low;
// the queue absorbs the backlog from items with two results.
// Reset: lexer state cleared, max_args back to 16, queue and output empty.
// When the receiver stalls, the output holds its result, the queue fills,
// and in_stall rises once it is full.
module quoted_argument_splitter #(
	parameter int ARG_LEN_CAP = qas_pkg::DEF_ARG_LEN_CAP
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] max_args,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] data,
	output logic [1:0] status,
	output logic       truncated,
	output logic       dropped,
	output logic [7:0] arg_count,
	output logic       last
);
	import qas_pkg::*;

	ent_t ent, head;
	logic ent_valid, pop, empty, full, in_acc;

	assign in_stall  = full;
	assign in_acc    = in_valid && !full;
	assign cfg_ready = 1'b1;

	qas_front #(.ARG_LEN_CAP(ARG_LEN_CAP)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.ch       (ch),
		.in_acc   (in_acc),
		.cfg_we   (cfg_valid),
		.cfg_data (max_args),
		.ent_valid(ent_valid),
		.ent      (ent)
	);

	qas_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (ent_valid),
		.push_ent(ent),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.full    (full)
	);

	qas_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind     (kind),
		.data     (data),
		.status   (status),
		.truncated(truncated),
		.dropped  (dropped),
		.arg_count(arg_count),
		.last     (last)
	);

endmodule
